>>> rtl/imhq_pkg.sv
`default_nettype none
package imhq_pkg;

    localparam int HEAP_DEPTH = 64;
    localparam int ADDR_W     = $clog2(HEAP_DEPTH);
    localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);
    localparam int KEY_SPACE  = 256;
    localparam int KEY_W      = $clog2(KEY_SPACE);
    localparam int PRIO_W     = 32;
    localparam int STATUS_W   = 3;
    localparam int MODE_W     = 2;
    // child index of the deepest slot needs two more bits than a slot address
    localparam int CHILD_W    = ADDR_W + 2;

    localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EXISTS = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOKEY  = 3'd4;

    localparam logic [MODE_W-1:0] MODE_PUSH   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POP    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CHANGE = 2'd2;

    localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(HEAP_DEPTH);

    typedef struct packed {
        logic [KEY_W-1:0]         key;
        logic signed [PRIO_W-1:0] prio;
    } entry_t;

endpackage
`default_nettype wire

>>> rtl/indexed_max_heap_queue_core.sv
// channel   | ports                                      | transfer
// ----------+--------------------------------------------+-------------------------
// command   | start, busy, mode, key, priority_req       | start && !busy
// result    | done, status, top_key, top_priority,       | done (one cycle, no stall)
//           | entry_count, is_empty                      |
// config    | cfg_we, cfg_wdata (capacity limit)         | cfg_we
//
// one command at a time: refused commands and pop of a single entry finish
// without a sift; a sift passes through its read and compare states once per
// level, up or down, over the single read port of the heap memory.
// the result strobe rises in the cycle after the last memory write.
// reset clears the count, the key presence flags and sets the capacity to 64.
// results cannot be stalled; busy holds off new commands while sifting.
`default_nettype none
module indexed_max_heap_queue_core
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic [imhq_pkg::MODE_W-1:0]        mode,
    input  wire logic [imhq_pkg::KEY_W-1:0]         key,
    input  wire logic signed [imhq_pkg::PRIO_W-1:0] priority_req,
    input  wire logic                               cfg_we,
    input  wire logic [imhq_pkg::CNT_W-1:0]         cfg_wdata,
    output logic                                    done,
    output logic [imhq_pkg::STATUS_W-1:0]           status,
    output logic [imhq_pkg::KEY_W-1:0]              top_key,
    output logic signed [imhq_pkg::PRIO_W-1:0]      top_priority,
    output logic [imhq_pkg::CNT_W-1:0]              entry_count,
    output logic                                    is_empty
);
    import imhq_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_POS    = 8'b0000_0010,
        S_POP_RD = 8'b0000_0100,
        S_UP_RD  = 8'b0000_1000,
        S_UP_CMP = 8'b0001_0000,
        S_DN_RDL = 8'b0010_0000,
        S_DN_RDR = 8'b0100_0000,
        S_DN_CMP = 8'b1000_0000
    } state_t;

    entry_t heap_mem [HEAP_DEPTH];
    logic [ADDR_W-1:0] pos_mem [KEY_SPACE];

    state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] cap_reg;
    logic [KEY_SPACE-1:0] present_reg, present_next;
    entry_t elem_reg, elem_next;
    entry_t left_reg, left_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic moved_reg, moved_next;
    logic up_after_reg, up_after_next;
    logic has_right_reg, has_right_next;
    logic done_reg, done_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    entry_t top_reg;

    logic hw_en;
    logic [ADDR_W-1:0] hw_addr;
    entry_t hw_data;
    logic hr_en;
    logic [ADDR_W-1:0] hr_addr;
    entry_t hr_data;
    logic pw_en;
    logic [KEY_W-1:0] pw_addr;
    logic [ADDR_W-1:0] pw_data;
    logic pr_en;
    logic [ADDR_W-1:0] pr_data;

    logic [CNT_W-1:0] cap_eff;
    logic [CHILD_W-1:0] left_idx, right_idx;
    logic [ADDR_W-1:0] parent_idx;
    logic pick_left;
    entry_t best;
    logic best_is_child;
    logic [ADDR_W-1:0] best_idx;

    assign cap_eff = (cap_reg > CNT_W'(HEAP_DEPTH)) ? CNT_W'(HEAP_DEPTH) : cap_reg;
    assign left_idx   = {1'b0, idx_reg, 1'b1};
    assign right_idx  = {1'b0, idx_reg, 1'b0} + CHILD_W'(2);
    assign parent_idx = (idx_reg - ADDR_W'(1)) >> 1;

    always_comb
    begin
        pick_left = elem_reg.prio < left_reg.prio;
        best = pick_left ? left_reg : elem_reg;
        best_idx = left_idx[ADDR_W-1:0];
        best_is_child = pick_left;
        if (has_right_reg && (best.prio < hr_data.prio))
        begin
            best = hr_data;
            best_idx = right_idx[ADDR_W-1:0];
            best_is_child = 1'b1;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        present_next  = present_reg;
        elem_next     = elem_reg;
        left_next     = left_reg;
        idx_next      = idx_reg;
        moved_next    = moved_reg;
        up_after_next = up_after_reg;
        has_right_next = has_right_reg;
        done_next     = 1'b0;
        status_next   = status_reg;
        hw_en = 1'b0;
        hw_addr = idx_reg;
        hw_data = elem_reg;
        hr_en = 1'b0;
        hr_addr = idx_reg;
        pw_en = 1'b0;
        pw_addr = elem_reg.key;
        pw_data = idx_reg;
        pr_en = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    elem_next = '{key: key, prio: priority_req};
                    status_next = ST_OK;
                    case (mode)
                        MODE_PUSH:
                        begin
                            if (count_reg >= cap_eff)
                            begin
                                status_next = ST_FULL;
                                done_next = 1'b1;
                            end
                            else if (present_reg[key])
                            begin
                                status_next = ST_EXISTS;
                                done_next = 1'b1;
                            end
                            else
                            begin
                                present_next[key] = 1'b1;
                                idx_next = count_reg[ADDR_W-1:0];
                                count_next = count_reg + CNT_W'(1);
                                state_next = S_UP_RD;
                            end
                        end
                        MODE_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                                done_next = 1'b1;
                            end
                            else
                            begin
                                present_next[top_reg.key] = 1'b0;
                                count_next = count_reg - CNT_W'(1);
                                if (count_next == '0)
                                    done_next = 1'b1;
                                else
                                begin
                                    hr_en = 1'b1;
                                    hr_addr = count_next[ADDR_W-1:0];
                                    state_next = S_POP_RD;
                                end
                            end
                        end
                        MODE_CHANGE:
                        begin
                            if (!present_reg[key])
                            begin
                                status_next = ST_NOKEY;
                                done_next = 1'b1;
                            end
                            else
                            begin
                                pr_en = 1'b1;
                                state_next = S_POS;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            S_POS:
            begin
                idx_next = pr_data;
                up_after_next = 1'b1;
                moved_next = 1'b0;
                state_next = S_DN_RDL;
            end
            S_POP_RD:
            begin
                elem_next = hr_data;
                idx_next = '0;
                up_after_next = 1'b0;
                moved_next = 1'b0;
                state_next = S_DN_RDL;
            end
            S_UP_RD:
            begin
                if (idx_reg == '0)
                begin
                    hw_en = 1'b1;
                    pw_en = 1'b1;
                    done_next = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    hr_en = 1'b1;
                    hr_addr = parent_idx;
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                hw_en = 1'b1;
                pw_en = 1'b1;
                if (hr_data.prio < elem_reg.prio)
                begin
                    // parent moves down into the hole
                    hw_data = hr_data;
                    pw_addr = hr_data.key;
                    idx_next = parent_idx;
                    state_next = S_UP_RD;
                end
                else
                begin
                    done_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_DN_RDL:
            begin
                if (CNT_W'(left_idx) >= count_reg)
                begin
                    if (up_after_reg && !moved_reg)
                        state_next = S_UP_RD;
                    else
                    begin
                        hw_en = 1'b1;
                        pw_en = 1'b1;
                        done_next = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    hr_en = 1'b1;
                    hr_addr = left_idx[ADDR_W-1:0];
                    state_next = S_DN_RDR;
                end
            end
            S_DN_RDR:
            begin
                left_next = hr_data;
                has_right_next = {1'b0, right_idx} < {1'b0, count_reg};
                if ({1'b0, right_idx} < {1'b0, count_reg})
                begin
                    hr_en = 1'b1;
                    hr_addr = right_idx[ADDR_W-1:0];
                end
                state_next = S_DN_CMP;
            end
            S_DN_CMP:
            begin
                if (best_is_child)
                begin
                    // larger child moves up into the hole
                    hw_en = 1'b1;
                    pw_en = 1'b1;
                    hw_data = best;
                    pw_addr = best.key;
                    idx_next = best_idx;
                    moved_next = 1'b1;
                    state_next = S_DN_RDL;
                end
                else if (up_after_reg && !moved_reg)
                    state_next = S_UP_RD;
                else
                begin
                    hw_en = 1'b1;
                    pw_en = 1'b1;
                    done_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (hw_en)
            heap_mem[hw_addr] <= hw_data;
        if (hr_en)
            hr_data <= heap_mem[hr_addr];
        if (pw_en)
            pos_mem[pw_addr] <= pw_data;
        if (pr_en)
            pr_data <= pos_mem[key];
    end

    always_ff @(posedge clk)
    begin
        elem_reg <= elem_next;
        left_reg <= left_next;
        idx_reg <= idx_next;
        moved_reg <= moved_next;
        up_after_reg <= up_after_next;
        has_right_reg <= has_right_next;
        status_reg <= status_next;
        // root copy follows every write to slot zero
        if (hw_en && (hw_addr == '0))
            top_reg <= hw_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            present_reg <= '0;
            cap_reg <= CAP_RESET;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            present_reg <= present_next;
            done_reg <= done_next;
            if (cfg_we)
                cap_reg <= cfg_wdata;
        end
    end

    assign busy = state_reg != S_IDLE;
    assign done = done_reg;
    assign status = status_reg;
    assign entry_count = count_reg;
    assign is_empty = count_reg == '0;
    assign top_key = is_empty ? '0 : top_reg.key;
    assign top_priority = is_empty ? '0 : top_reg.prio;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while sifting");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        entry_count <= CNT_W'(HEAP_DEPTH))
        else $error("entry count above heap depth");

    a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && mode == MODE_POP && entry_count == '0)
        |=> (done && status == ST_EMPTY))
        else $error("pop of empty heap not reported");

    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> $stable(entry_count))
        else $error("entry count changed during sift");

endmodule
`default_nettype wire

>>> tb/imhq_checker.sv
module imhq_checker
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 start,
    input  wire logic                                 busy,
    input  wire logic [imhq_pkg::MODE_W-1:0]          mode,
    input  wire logic [imhq_pkg::KEY_W-1:0]           key,
    input  wire logic signed [imhq_pkg::PRIO_W-1:0]   priority_req,
    input  wire logic                                 cfg_we,
    input  wire logic [imhq_pkg::CNT_W-1:0]           cfg_wdata,
    input  wire logic                                 done,
    input  wire logic [imhq_pkg::STATUS_W-1:0]        status,
    input  wire logic [imhq_pkg::KEY_W-1:0]           top_key,
    input  wire logic signed [imhq_pkg::PRIO_W-1:0]   top_priority,
    input  wire logic [imhq_pkg::CNT_W-1:0]           entry_count,
    input  wire logic                                 is_empty,
    output int                                        fail_count,
    output int                                        pending
);
    import imhq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic [KEY_W-1:0]         top_key;
        logic signed [PRIO_W-1:0] top_prio;
        logic [CNT_W-1:0]         count;
        logic                     empty;
    } heap_report_t;

    entry_t                 slots [HEAP_DEPTH];
    logic [CNT_W-1:0]       where_is [KEY_SPACE];
    int                     held;
    logic [CNT_W-1:0]       cap_reg;
    heap_report_t           expected_reports [$];

    function automatic void swap_slots(int a, int b);
        entry_t t;
        t = slots[a];
        slots[a] = slots[b];
        slots[b] = t;
        where_is[slots[a].key] = CNT_W'(a + 1);
        where_is[slots[b].key] = CNT_W'(b + 1);
    endfunction

    function automatic void bubble_up(int idx);
        int parent;
        while (idx != 0)
        begin
            parent = (idx - 1) / 2;
            if (!(slots[parent].prio < slots[idx].prio))
                break;
            swap_slots(idx, parent);
            idx = parent;
        end
    endfunction

    function automatic void bubble_down(int idx);
        int best;
        forever
        begin
            best = idx;
            if (2 * idx + 1 < held && slots[best].prio < slots[2 * idx + 1].prio)
                best = 2 * idx + 1;
            if (2 * idx + 2 < held && slots[best].prio < slots[2 * idx + 2].prio)
                best = 2 * idx + 2;
            if (best == idx)
                break;
            swap_slots(idx, best);
            idx = best;
        end
    endfunction

    function automatic heap_report_t apply_command(logic [MODE_W-1:0] m,
                                                   logic [KEY_W-1:0] k,
                                                   logic signed [PRIO_W-1:0] p);
        heap_report_t r;
        int cap;
        int idx;
        r = '0;
        r.status = ST_OK;
        cap = (cap_reg > HEAP_DEPTH) ? HEAP_DEPTH : int'(cap_reg);
        if (m == MODE_PUSH)
        begin
            if (held >= cap)
                r.status = ST_FULL;
            else if (where_is[k] != 0)
                r.status = ST_EXISTS;
            else
            begin
                slots[held].key = k;
                slots[held].prio = p;
                where_is[k] = CNT_W'(held + 1);
                held++;
                bubble_up(held - 1);
            end
        end
        else if (m == MODE_POP)
        begin
            if (held == 0)
                r.status = ST_EMPTY;
            else
            begin
                where_is[slots[0].key] = '0;
                held--;
                if (held != 0)
                begin
                    slots[0] = slots[held];
                    where_is[slots[0].key] = CNT_W'(1);
                    bubble_down(0);
                end
            end
        end
        else if (m == MODE_CHANGE)
        begin
            if (where_is[k] == 0 || int'(where_is[k]) - 1 >= held)
                r.status = ST_NOKEY;
            else
            begin
                idx = int'(where_is[k]) - 1;
                slots[idx].prio = p;
                bubble_down(idx);
                bubble_up(int'(where_is[k]) - 1);
            end
        end
        if (held != 0)
        begin
            r.top_key = slots[0].key;
            r.top_prio = slots[0].prio;
        end
        r.count = CNT_W'(held);
        r.empty = (held == 0);
        return r;
    endfunction

    assign pending = expected_reports.size();

    always @(posedge clk or negedge rst_n)
    begin
        heap_report_t exp_r;
        heap_report_t got;
        heap_report_t fresh;
        if (!rst_n)
        begin
            held = 0;
            cap_reg = CAP_RESET;
            foreach (where_is[i])
                where_is[i] = '0;
            foreach (slots[i])
                slots[i] = '0;
            expected_reports.delete();
            fail_count = 0;
        end
        else
        begin
            if (cfg_we)
                cap_reg = cfg_wdata;
            if (start && !busy)
            begin
                fresh = apply_command(mode, key, priority_req);
                expected_reports = {expected_reports, fresh};
            end
            if (done)
            begin
                got = '{status, top_key, top_priority, entry_count, is_empty};
                if (expected_reports.size() == 0)
                begin
                    $display("%0t: result with none expected: got %h", $time, got);
                    fail_count++;
                end
                else
                begin
                    exp_r = expected_reports.pop_front();
                    if (got.status !== exp_r.status)
                    begin
                        $display("%0t: status exp %0d got %0d", $time, exp_r.status, got.status);
                        fail_count++;
                    end
                    if (got.top_key !== exp_r.top_key)
                    begin
                        $display("%0t: top_key exp %0d got %0d", $time, exp_r.top_key,
                                 got.top_key);
                        fail_count++;
                    end
                    if (got.top_prio !== exp_r.top_prio)
                    begin
                        $display("%0t: top_priority exp %0d got %0d", $time, exp_r.top_prio,
                                 got.top_prio);
                        fail_count++;
                    end
                    if (got.count !== exp_r.count)
                    begin
                        $display("%0t: entry_count exp %0d got %0d", $time, exp_r.count,
                                 got.count);
                        fail_count++;
                    end
                    if (got.empty !== exp_r.empty)
                    begin
                        $display("%0t: is_empty exp %0d got %0d", $time, exp_r.empty,
                                 got.empty);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

>>> tb/tb_indexed_max_heap_queue_core.sv
module tb_indexed_max_heap_queue_core;
    import imhq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    // mode code with no operation behind it
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    logic                       clk;
    logic                       rst_n;
    logic                       start;
    logic                       busy;
    logic [MODE_W-1:0]          mode;
    logic [KEY_W-1:0]           key;
    logic signed [PRIO_W-1:0]   priority_req;
    logic                       cfg_we;
    logic [CNT_W-1:0]           cfg_wdata;
    logic                       done;
    logic [STATUS_W-1:0]        status;
    logic [KEY_W-1:0]           top_key;
    logic signed [PRIO_W-1:0]   top_priority;
    logic [CNT_W-1:0]           entry_count;
    logic                       is_empty;
    int                         fail_count;
    int                         pending;
    int                         cycles;
    bit                         quiet_sender;

    indexed_max_heap_queue_core DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .mode(mode), .key(key),
        .priority_req(priority_req), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .done(done),
        .status(status), .top_key(top_key), .top_priority(top_priority),
        .entry_count(entry_count), .is_empty(is_empty)
    );

    imhq_checker u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .mode(mode), .key(key),
        .priority_req(priority_req), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .done(done),
        .status(status), .top_key(top_key), .top_priority(top_priority),
        .entry_count(entry_count), .is_empty(is_empty), .fail_count(fail_count),
        .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // one command transfer, with random idle before it; start stays high
    // after the transfer so the next command can follow right away
    task automatic issue(logic [MODE_W-1:0] m, logic [KEY_W-1:0] k,
                         logic signed [PRIO_W-1:0] p);
        if (!quiet_sender && $urandom_range(99) < 8)
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < 8);
        end
        start <= 1'b1;
        mode <= m;
        key <= k;
        priority_req <= p;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic drain;
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic set_capacity(logic [CNT_W-1:0] v);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic signed [PRIO_W-1:0] rand_prio();
        case ($urandom_range(5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return PRIO_W'($urandom_range(7)) - 3;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_phase(int n, int key_span);
        int r;
        for (int i = 0; i < n; i++)
        begin
            quiet_sender = (i >= n / 3 && i < n / 2);
            r = $urandom_range(99);
            if (r < 45)
                issue(MODE_PUSH, KEY_W'($urandom_range(key_span)), rand_prio());
            else if (r < 70)
                issue(MODE_POP, KEY_W'($urandom), $urandom);
            else if (r < 97)
                issue(MODE_CHANGE, KEY_W'($urandom_range(key_span)), rand_prio());
            else
                issue(MODE_SPARE, KEY_W'($urandom), $urandom);
        end
        quiet_sender = 1'b0;
    endtask

    initial
    begin
        cycles = 0;
        quiet_sender = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        mode = MODE_PUSH;
        key = '0;
        priority_req = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty queue, extremes, duplicate key, absent key, unused mode
        issue(MODE_POP, 8'd0, 0);
        issue(MODE_CHANGE, 8'd5, 7);
        issue(MODE_SPARE, 8'hff, 32'hffffffff);
        issue(MODE_PUSH, 8'd0, 32'sh80000000);
        issue(MODE_PUSH, 8'hff, 32'sh7fffffff);
        issue(MODE_PUSH, 8'hff, 1);
        issue(MODE_PUSH, 8'h55, 32'sh7fffffff);
        issue(MODE_PUSH, 8'haa, -1);
        issue(MODE_CHANGE, 8'd0, 32'sh7fffffff);
        issue(MODE_CHANGE, 8'hff, 32'sh80000000);
        issue(MODE_CHANGE, 8'h12, 3);
        issue(MODE_SPARE, 8'd0, 0);
        for (int i = 0; i < 5; i++)
            issue(MODE_POP, 8'd0, 0);

        // capacity zero refuses every push
        set_capacity(7'd0);
        issue(MODE_PUSH, 8'd1, 1);
        // capacity one, then a push beyond it
        set_capacity(7'd1);
        issue(MODE_PUSH, 8'd1, 1);
        issue(MODE_PUSH, 8'd2, 2);
        issue(MODE_CHANGE, 8'd1, 9);
        // capacity above depth acts as depth
        set_capacity(7'd127);
        random_phase(300, 255);
        // fill the heap with few keys so it runs full
        random_phase(250, 90);
        set_capacity(7'd5);
        random_phase(150, 15);
        set_capacity(7'd64);
        random_phase(250, 255);
        set_capacity(7'd20);
        random_phase(150, 40);
        set_capacity(7'd64);
        for (int i = 0; i < 70; i++)
            issue(MODE_PUSH, KEY_W'(i), rand_prio());
        random_phase(130, 80);
        drain();

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
